// ===== rtl/kti_pkg.sv =====
// Shared types and constants of the keyframe track interpolator.
// No dependencies; used by kti_muldiv and the top module.
`default_nettype none

package kti_pkg;

  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_VALUE_BITS = 16;
  localparam int DEF_TIME_BITS  = 32;

  localparam int MODE_BITS      = 2;
  localparam int CHANNEL_BITS   = 2;
  localparam int SAMPLE_BITS    = 16;
  localparam int TARGET_BITS    = 16;
  localparam int SOURCE_BITS    = 3;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MASK_BITS      = 4;
  localparam int DEFAULT_REGS   = 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  localparam logic [SOURCE_BITS-1:0] SRC_DEFAULT = 3'd0;
  localparam logic [SOURCE_BITS-1:0] SRC_FIRST   = 3'd1;
  localparam logic [SOURCE_BITS-1:0] SRC_LAST    = 3'd2;
  localparam logic [SOURCE_BITS-1:0] SRC_INTERP  = 3'd3;
  localparam logic [SOURCE_BITS-1:0] SRC_NONE    = 3'd4;

  localparam logic [STATUS_BITS-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STS_FULL     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STS_NOT_INC  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STS_NO_ROW   = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINEAR_MASK = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_CH0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_CH1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_CH2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_CH3 = 3'd4;

  localparam logic [MASK_BITS-1:0] MASK_RESET = 4'hF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APP_CLR,
    ST_RS_RD,
    ST_RS_EV,
    ST_BS_RD,
    ST_BS_CMP,
    ST_EDGE_RD,
    ST_EDGE_EV,
    ST_L_RD,
    ST_L_EV,
    ST_R_RD,
    ST_R_EV,
    ST_LERP,
    ST_MD_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic start;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

// ===== rtl/kti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/kti_muldiv.sv =====
// Iterative multiply-then-divide unit: quo = (a * b) / d, rem_nz = remainder != 0.
// Shift-add multiply, then restoring divide, one bit a cycle. Uses kti_pkg.
`default_nettype none

module kti_muldiv #(
  parameter int A_BITS = 32,
  parameter int B_BITS = 17,
  parameter int D_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kti_pkg::md_ctrl_t ctrl,
  output kti_pkg::md_stat_t      stat,
  input  wire logic [A_BITS-1:0] a,
  input  wire logic [B_BITS-1:0] b,
  input  wire logic [D_BITS-1:0] d,
  output logic      [B_BITS-1:0] quo,
  output logic                   rem_nz
);

  import kti_pkg::*;

  localparam int P_BITS   = A_BITS + B_BITS;
  localparam int CNT_BITS = $clog2(P_BITS + 1);

  md_state_t             state, state_next;
  logic [P_BITS-1:0]     a_sh, a_sh_next;
  logic [B_BITS-1:0]     b_sh, b_sh_next;
  logic [P_BITS-1:0]     prod, prod_next;
  logic [D_BITS-1:0]     d_q, d_q_next;
  logic [D_BITS-1:0]     rem, rem_next;
  logic [B_BITS-1:0]     quo_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic                  done, done_next;
  logic [D_BITS:0]       rem_sh;
  logic                  ge;

  assign rem_sh = {rem, prod[P_BITS-1]};
  assign ge     = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    a_sh <= a_sh_next;
    b_sh <= b_sh_next;
    prod <= prod_next;
    d_q  <= d_q_next;
    rem  <= rem_next;
    quo  <= quo_next;
    cnt  <= cnt_next;
  end

  always_comb begin
    state_next = state;
    a_sh_next  = a_sh;
    b_sh_next  = b_sh;
    prod_next  = prod;
    d_q_next   = d_q;
    rem_next   = rem;
    quo_next   = quo;
    cnt_next   = cnt;
    done_next  = 1'b0;
    unique case (state)
      MD_IDLE: begin
        if (ctrl.start) begin
          a_sh_next  = P_BITS'(a);
          b_sh_next  = b;
          d_q_next   = d;
          prod_next  = '0;
          cnt_next   = CNT_BITS'(B_BITS);
          state_next = MD_MUL;
        end
      end
      MD_MUL: begin
        if (b_sh[0]) begin
          prod_next = prod + a_sh;
        end
        a_sh_next = a_sh << 1;
        b_sh_next = b_sh >> 1;
        cnt_next  = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          cnt_next   = CNT_BITS'(P_BITS);
          rem_next   = '0;
          quo_next   = '0;
          state_next = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_next  = ge ? D_BITS'(rem_sh - {1'b0, d_q}) : rem_sh[D_BITS-1:0];
        quo_next  = {quo[B_BITS-2:0], ge};
        prod_next = prod << 1;
        cnt_next  = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done_next  = 1'b1;
          state_next = MD_IDLE;
        end
      end
      default: state_next = MD_IDLE;
    endcase
  end

  assign rem_nz    = |rem;
  assign stat.busy = state != MD_IDLE;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== rtl/keyframe_track_interpolator.sv =====
// Keyframe track interpolator: time-sorted row table with per-channel values,
// interpolating queries. Uses kti_pkg, kti_ram and kti_muldiv.
//
// Usage: one input word per item on in_valid/in_ready, one result word per
// item on out_valid/out_ready, register writes on cfg_valid/cfg_ready (always
// ready; write only while idle). in_ready is high only while the sequencer is
// idle; a finished result sits in the output register and the next word is
// taken while it waits. If the receiver stalls, the following item finishes
// its work and holds until the output register frees.
// Steps per item: clear empties the table; append writes the row time and
// marks every channel of the new row missing; write stores the value and
// rescans that one channel, a read and an evaluate state per row through the
// registered value memory read port; query runs a binary search on the row
// times, a neighbor scan and, for a linear channel, the multiply/divide unit.
// Reset clears the row count and channel summaries at once; the row memories
// need no clearing pass.
`default_nettype none

module keyframe_track_interpolator #(
  parameter int MAX_ROWS   = kti_pkg::DEF_MAX_ROWS,
  parameter int CHANNELS   = kti_pkg::DEF_CHANNELS,
  parameter int VALUE_BITS = kti_pkg::DEF_VALUE_BITS,
  parameter int TIME_BITS  = kti_pkg::DEF_TIME_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [kti_pkg::MODE_BITS-1:0]         mode,
  input  wire logic [TIME_BITS-1:0]                  time_ms,
  input  wire logic [kti_pkg::CHANNEL_BITS-1:0]      channel,
  input  wire logic signed [kti_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                  present,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [kti_pkg::TARGET_BITS-1:0]     target,
  output logic [kti_pkg::SOURCE_BITS-1:0]            source,
  output logic [kti_pkg::STATUS_BITS-1:0]            status,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [kti_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [kti_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  import kti_pkg::*;

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int NW   = RW + 1;
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VAW  = $clog2(MAX_ROWS * CHANNELS);
  localparam int CW   = (VALUE_BITS > SAMPLE_BITS) ? VALUE_BITS : SAMPLE_BITS;
  localparam int BW   = CW + 1;

  function automatic logic [VAW-1:0] vaddr(input logic [RW-1:0] row,
                                           input logic [CIW-1:0] ch);
    return VAW'(int'(row) * CHANNELS + int'(ch));
  endfunction

  state_t                       state, state_next;
  mode_t                        mode_q, mode_q_next;
  logic [TIME_BITS-1:0]         t_q, t_q_next;
  logic [CHANNEL_BITS-1:0]      c_q, c_q_next;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_q_next;
  logic                         pres_q, pres_q_next;
  logic [NW-1:0]                row_count, row_count_next;
  logic [TIME_BITS-1:0]         last_time, last_time_next;
  logic                         has [CHANNELS];
  logic                         has_next [CHANNELS];
  logic signed [CW-1:0]         earliest [CHANNELS];
  logic signed [CW-1:0]         earliest_next [CHANNELS];
  logic signed [CW-1:0]         latest [CHANNELS];
  logic signed [CW-1:0]         latest_next [CHANNELS];
  logic [MASK_BITS-1:0]         linear_mask, linear_mask_next;
  logic [CFG_DATA_BITS-1:0]     default_regs [DEFAULT_REGS];
  logic [CFG_DATA_BITS-1:0]     default_regs_next [DEFAULT_REGS];
  logic [NW-1:0]                lo, lo_next, hi, hi_next, mid;
  logic [RW-1:0]                j, j_next;
  logic [CIW-1:0]               k, k_next;
  logic                         edge_first, edge_first_next;
  logic signed [CW-1:0]         pl, pl_next, pr, pr_next;
  logic [TIME_BITS-1:0]         tl, tl_next, tr, tr_next;
  logic signed [TARGET_BITS-1:0] res_target, res_target_next;
  logic [SOURCE_BITS-1:0]       res_source, res_source_next;
  logic [STATUS_BITS-1:0]       res_status, res_status_next;
  logic                         out_valid_next;
  logic signed [TARGET_BITS-1:0] target_next;
  logic [SOURCE_BITS-1:0]       source_next;
  logic [STATUS_BITS-1:0]       status_next;

  logic                         time_we;
  logic [RW-1:0]                time_waddr, time_raddr;
  logic [TIME_BITS-1:0]         time_wdata, time_rdata;
  logic                         val_we;
  logic [VAW-1:0]               val_waddr, val_raddr;
  logic [VALUE_BITS:0]          val_wdata, val_rdata;

  md_ctrl_t                     md_ctrl;
  md_stat_t                     md_stat;
  logic [BW-1:0]                md_quo;
  logic                         md_rem_nz;

  logic [CIW-1:0]               ci;
  logic                         ch_ok;
  logic signed [CW-1:0]         dflt, rd_val, fb_first, fb_last;
  logic                         rd_present;
  logic                         neg;
  logic [TIME_BITS-1:0]         dt, den;
  logic signed [BW:0]           pl_x, pr_x, q_x, base, base_adj;
  logic [BW-1:0]                dp;

  kti_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_ROWS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (time_wdata),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  kti_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(MAX_ROWS * CHANNELS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  kti_muldiv #(.A_BITS(TIME_BITS), .B_BITS(BW), .D_BITS(TIME_BITS)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (md_ctrl),
    .stat   (md_stat),
    .a      (dt),
    .b      (dp),
    .d      (den),
    .quo    (md_quo),
    .rem_nz (md_rem_nz)
  );

  assign ci         = c_q[CIW-1:0];
  assign ch_ok      = 32'(c_q) < CHANNELS;
  assign dflt       = CW'($signed(default_regs[c_q]));
  assign rd_val     = CW'($signed(val_rdata[VALUE_BITS-1:0]));
  assign rd_present = val_rdata[VALUE_BITS];
  assign fb_first   = has[ci] ? earliest[ci] : dflt;
  assign fb_last    = has[ci] ? latest[ci] : dflt;
  assign mid        = lo + ((hi - lo) >> 1);

  // Linear interpolation operands; tl <= t_q < tr holds for a middle query
  assign dt   = t_q - tl;
  assign den  = tr - tl;
  assign pl_x = (BW + 1)'(pl);
  assign pr_x = (BW + 1)'(pr);
  assign neg  = pr < pl;
  assign dp   = neg ? BW'(pl_x - pr_x) : BW'(pr_x - pl_x);
  assign q_x  = $signed({1'b0, md_quo});
  assign base = neg ? pl_x - q_x : pl_x + q_x;

  // Truncate toward zero when the division was inexact
  always_comb begin
    base_adj = base;
    if (md_rem_nz) begin
      if (!neg && base < 0) begin
        base_adj = base + (BW + 1)'(1);
      end else if (neg && base > 0) begin
        base_adj = base - (BW + 1)'(1);
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      row_count   <= '0;
      linear_mask <= MASK_RESET;
      for (int n = 0; n < CHANNELS; n++) begin
        has[n]      <= 1'b0;
        earliest[n] <= '0;
        latest[n]   <= '0;
      end
      for (int n = 0; n < DEFAULT_REGS; n++) begin
        default_regs[n] <= '0;
      end
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      row_count   <= row_count_next;
      linear_mask <= linear_mask_next;
      for (int n = 0; n < CHANNELS; n++) begin
        has[n]      <= has_next[n];
        earliest[n] <= earliest_next[n];
        latest[n]   <= latest_next[n];
      end
      for (int n = 0; n < DEFAULT_REGS; n++) begin
        default_regs[n] <= default_regs_next[n];
      end
    end
    mode_q     <= mode_q_next;
    t_q        <= t_q_next;
    c_q        <= c_q_next;
    sample_q   <= sample_q_next;
    pres_q     <= pres_q_next;
    last_time  <= last_time_next;
    lo         <= lo_next;
    hi         <= hi_next;
    j          <= j_next;
    k          <= k_next;
    edge_first <= edge_first_next;
    pl         <= pl_next;
    pr         <= pr_next;
    tl         <= tl_next;
    tr         <= tr_next;
    res_target <= res_target_next;
    res_source <= res_source_next;
    res_status <= res_status_next;
    target     <= target_next;
    source     <= source_next;
    status     <= status_next;
  end

  always_comb begin
    state_next       = state;
    mode_q_next      = mode_q;
    t_q_next         = t_q;
    c_q_next         = c_q;
    sample_q_next    = sample_q;
    pres_q_next      = pres_q;
    row_count_next   = row_count;
    last_time_next   = last_time;
    linear_mask_next = linear_mask;
    for (int n = 0; n < CHANNELS; n++) begin
      has_next[n]      = has[n];
      earliest_next[n] = earliest[n];
      latest_next[n]   = latest[n];
    end
    for (int n = 0; n < DEFAULT_REGS; n++) begin
      default_regs_next[n] = default_regs[n];
    end
    lo_next          = lo;
    hi_next          = hi;
    j_next           = j;
    k_next           = k;
    edge_first_next  = edge_first;
    pl_next          = pl;
    pr_next          = pr;
    tl_next          = tl;
    tr_next          = tr;
    res_target_next  = res_target;
    res_source_next  = res_source;
    res_status_next  = res_status;
    target_next      = target;
    source_next      = source;
    status_next      = status;
    out_valid_next   = out_valid && !out_ready;
    in_ready         = 1'b0;
    time_we          = 1'b0;
    time_waddr       = row_count[RW-1:0];
    time_wdata       = t_q;
    time_raddr       = j;
    val_we           = 1'b0;
    val_waddr        = vaddr(j, ci);
    val_wdata        = '0;
    val_raddr        = vaddr(j, ci);
    md_ctrl.start    = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINEAR_MASK: linear_mask_next = cfg_data[MASK_BITS-1:0];
        REG_DEFAULT_CH0: default_regs_next[0] = cfg_data;
        REG_DEFAULT_CH1: default_regs_next[1] = cfg_data;
        REG_DEFAULT_CH2: default_regs_next[2] = cfg_data;
        REG_DEFAULT_CH3: default_regs_next[3] = cfg_data;
        default: ;
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_q_next   = mode_t'(mode);
          t_q_next      = time_ms;
          c_q_next      = channel;
          sample_q_next = sample;
          pres_q_next   = present;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_target_next = '0;
        res_source_next = SRC_NONE;
        res_status_next = STS_OK;
        state_next      = ST_DONE;
        unique case (mode_q)
          MODE_CLEAR: begin
            row_count_next = '0;
            for (int n = 0; n < CHANNELS; n++) begin
              has_next[n]      = 1'b0;
              earliest_next[n] = '0;
              latest_next[n]   = '0;
            end
          end
          MODE_APPEND: begin
            if (row_count >= NW'(MAX_ROWS)) begin
              res_status_next = STS_FULL;
            end else if (row_count != '0 && t_q <= last_time) begin
              res_status_next = STS_NOT_INC;
            end else begin
              time_we    = 1'b1;
              k_next     = '0;
              state_next = ST_APP_CLR;
            end
          end
          MODE_WRITE: begin
            if (row_count == '0) begin
              res_status_next = STS_NO_ROW;
            end else if (ch_ok) begin
              val_we    = 1'b1;
              val_waddr = vaddr(RW'(row_count - 1'b1), ci);
              val_wdata = pres_q ? {1'b1, VALUE_BITS'(CW'(sample_q))} : '0;
              has_next[ci]      = 1'b0;
              earliest_next[ci] = '0;
              latest_next[ci]   = '0;
              j_next     = '0;
              state_next = ST_RS_RD;
            end
          end
          MODE_QUERY: begin
            res_source_next = SRC_DEFAULT;
            if (ch_ok && row_count == '0) begin
              res_target_next = dflt[TARGET_BITS-1:0];
            end else if (ch_ok) begin
              lo_next    = '0;
              hi_next    = row_count;
              state_next = ST_BS_RD;
            end
          end
          default: ;
        endcase
      end
      ST_APP_CLR: begin
        // mark every channel of the new row missing
        val_we    = 1'b1;
        val_waddr = vaddr(row_count[RW-1:0], k);
        val_wdata = '0;
        if (k == CIW'(CHANNELS - 1)) begin
          row_count_next = row_count + 1'b1;
          last_time_next = t_q;
          state_next     = ST_DONE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_RS_RD: state_next = ST_RS_EV;
      ST_RS_EV: begin
        if (rd_present) begin
          if (!has[ci]) begin
            earliest_next[ci] = rd_val;
          end
          latest_next[ci] = rd_val;
          has_next[ci]    = 1'b1;
        end
        if (NW'(j) == row_count - 1'b1) begin
          state_next = ST_DONE;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_RS_RD;
        end
      end
      ST_BS_RD: begin
        time_raddr = mid[RW-1:0];
        if (lo < hi) begin
          state_next = ST_BS_CMP;
        end else if (lo == '0 || row_count == NW'(1)) begin
          j_next          = '0;
          edge_first_next = 1'b1;
          res_source_next = SRC_FIRST;
          state_next      = ST_EDGE_RD;
        end else if (lo >= row_count) begin
          j_next          = RW'(row_count - 1'b1);
          edge_first_next = 1'b0;
          res_source_next = SRC_LAST;
          state_next      = ST_EDGE_RD;
        end else begin
          j_next          = RW'(lo - 1'b1);
          res_source_next = SRC_INTERP;
          state_next      = ST_L_RD;
        end
      end
      ST_BS_CMP: begin
        if (time_rdata > t_q) begin
          hi_next = mid;
        end else begin
          lo_next = mid + 1'b1;
        end
        state_next = ST_BS_RD;
      end
      ST_EDGE_RD: state_next = ST_EDGE_EV;
      ST_EDGE_EV: begin
        if (rd_present) begin
          res_target_next = rd_val[TARGET_BITS-1:0];
        end else if (edge_first) begin
          res_target_next = fb_first[TARGET_BITS-1:0];
        end else begin
          res_target_next = fb_last[TARGET_BITS-1:0];
        end
        state_next = ST_DONE;
      end
      ST_L_RD: state_next = ST_L_EV;
      ST_L_EV: begin
        if (NW'(j) == lo - 1'b1) begin
          tl_next = time_rdata;
        end
        if (rd_present) begin
          pl_next    = rd_val;
          tl_next    = time_rdata;
          j_next     = lo[RW-1:0];
          state_next = ST_R_RD;
        end else if (j == '0) begin
          pl_next    = fb_first;
          j_next     = lo[RW-1:0];
          state_next = ST_R_RD;
        end else begin
          j_next     = j - 1'b1;
          state_next = ST_L_RD;
        end
      end
      ST_R_RD: state_next = ST_R_EV;
      ST_R_EV: begin
        if (NW'(j) == lo) begin
          tr_next = time_rdata;
        end
        if (rd_present) begin
          pr_next    = rd_val;
          tr_next    = time_rdata;
          state_next = ST_LERP;
        end else if (NW'(j) == row_count - 1'b1) begin
          pr_next    = fb_last;
          state_next = ST_LERP;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_R_RD;
        end
      end
      ST_LERP: begin
        if (!linear_mask[c_q]) begin
          res_target_next = pl[TARGET_BITS-1:0];
          state_next      = ST_DONE;
        end else begin
          md_ctrl.start = 1'b1;
          state_next    = ST_MD_WAIT;
        end
      end
      ST_MD_WAIT: begin
        if (md_stat.done) begin
          res_target_next = base_adj[TARGET_BITS-1:0];
          state_next      = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          target_next    = res_target;
          source_next    = res_source;
          status_next    = res_status;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !md_stat.busy)
    else $error("muldiv unit busy while accepting a word");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    row_count <= NW'(MAX_ROWS))
    else $error("row count beyond table depth");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> state == ST_MD_WAIT)
    else $error("muldiv result arrived outside its wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accepting a word");
`endif

endmodule

`default_nettype wire
